// ===== rtl/pprb_pkg.sv =====
// Shared types, codes and reset values of the prefill playout ring buffer.
package pprb_pkg;

   localparam int RING_DEPTH_DEF = 128;

   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_CFG_WAIT  = 3'd1,
      MODE_CFG_PLAY  = 3'd2,
      MODE_STIM_WAIT = 3'd3,
      MODE_STIM_PLAY = 3'd4
   } mode_type;

   localparam logic [2:0] OP_STIM = 3'd0;
   localparam logic [2:0] OP_IDLE = 3'd1;
   localparam logic [2:0] OP_CFG  = 3'd2;
   localparam logic [2:0] OP_DATA = 3'd3;
   localparam logic [2:0] OP_TICK = 3'd4;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_FULL  = 2'd1;
   localparam logic [1:0] EV_EMPTY = 2'd2;

   localparam logic [1:0] CSR_PREFILL       = 2'd0;
   localparam logic [1:0] CSR_LEVEL_HIGH    = 2'd1;
   localparam logic [1:0] CSR_LEVEL_LOW     = 2'd2;
   localparam logic [1:0] CSR_LED_THRESHOLD = 2'd3;

   localparam logic [6:0] PREFILL_RST       = 7'd20;
   localparam logic [7:0] LEVEL_HIGH_RST    = 8'd141;
   localparam logic [7:0] LEVEL_LOW_RST     = 8'd186;
   localparam logic [7:0] LED_THRESHOLD_RST = 8'd128;

   localparam logic [7:0] LEVEL_FULL = 8'd255;
   localparam logic [6:0] OCC_MAX    = 7'd127;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] data_byte;
      logic [2:0] periods;
   } item_type;

   typedef struct packed {
      logic       dac_valid;
      logic       dac_from_ring;
      logic [7:0] dac_value;
      logic       led_valid;
      logic       led_from_ring;
      mode_type   mode;
      logic [1:0] event_res;
      logic [6:0] occupancy;
   } result_type;

   // floor(x / 255) for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
      return t[15:8];
   endfunction

endpackage

// ===== rtl/pprb_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module pprb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pprb_pkg::RING_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pprb_scale.sv =====
// Level scaling of a data byte: weighted product registered, then divide by 255.
module pprb_scale (
   input  logic       clock,
   input  logic       load,
   input  logic [7:0] data_byte,
   input  logic [7:0] level_low,
   input  logic [7:0] level_high,
   output logic [7:0] scaled
);

   logic [15:0] low_term;
   logic [15:0] high_term;
   logic [15:0] product_in;
   logic [15:0] product_ff;

   assign low_term   = 16'(level_low) * 16'(pprb_pkg::LEVEL_FULL - data_byte);
   assign high_term  = 16'(level_high) * 16'(data_byte);
   assign product_in = low_term + high_term;

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   assign scaled = pprb_pkg::div255(product_ff);

endmodule

// ===== rtl/pprb_ctrl.sv =====
// Mode sequencer and ring index control; one transaction committed per fire.
module pprb_ctrl #(
   parameter int RING_DEPTH = pprb_pkg::RING_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  pprb_pkg::item_type            item,
   input  logic [7:0]                    scaled,
   input  logic [6:0]                    prefill_level,
   input  logic [7:0]                    midpoint,
   output logic                          ram_we,
   output logic [$clog2(RING_DEPTH)-1:0] ram_waddr,
   output logic [7:0]                    ram_wdata,
   output logic                          ram_re,
   output logic [$clog2(RING_DEPTH)-1:0] ram_raddr,
   output pprb_pkg::result_type          result
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = (AW > 7) ? AW : 7;

   function automatic logic [AW-1:0] ring_fill(input logic [AW-1:0] w, input logic [AW-1:0] r);
      logic [AW:0] wrapped;
      wrapped = (AW+1)'(RING_DEPTH) - {1'b0, r} + {1'b0, w};
      if (w >= r) begin
         return w - r;
      end
      return wrapped[AW-1:0];
   endfunction

   pprb_pkg::mode_type mode_ff;
   pprb_pkg::mode_type mode_in;
   logic [AW-1:0]      rd_ff;
   logic [AW-1:0]      rd_in;
   logic [AW-1:0]      wr_ff;
   logic [AW-1:0]      wr_in;

   logic [AW-1:0] occ_pre;
   logic [CW-1:0] occ_pre_cw;
   logic [CW-1:0] occ_post_cw;
   logic [CW-1:0] adv_cw;
   logic [AW:0]   rd_sum;
   logic [AW-1:0] rd_adv;
   logic [AW-1:0] wr_inc;
   logic          is_cfg;
   logic          prefill_hit;
   logic          full_hit;
   logic          play;

   logic       dac_valid;
   logic       dac_from_ring;
   logic [7:0] dac_value;
   logic       led_valid;
   logic       led_from_ring;
   logic [1:0] event_res;

   assign occ_pre     = ring_fill(wr_ff, rd_ff);
   assign occ_pre_cw  = CW'(occ_pre);
   assign is_cfg      = (mode_ff == pprb_pkg::MODE_CFG_WAIT) ||
                        (mode_ff == pprb_pkg::MODE_CFG_PLAY);
   assign prefill_hit = occ_pre_cw > CW'(prefill_level);
   assign wr_inc      = (wr_ff == AW'(RING_DEPTH - 1)) ? '0 : wr_ff + AW'(1);
   assign full_hit    = wr_inc == rd_ff;
   assign adv_cw      = (CW'(item.periods) < occ_pre_cw) ? CW'(item.periods) : occ_pre_cw;
   assign rd_sum      = {1'b0, rd_ff} + (AW+1)'(adv_cw);
   assign rd_adv      = (rd_sum >= (AW+1)'(RING_DEPTH)) ?
                        AW'(rd_sum - (AW+1)'(RING_DEPTH)) : rd_sum[AW-1:0];
   assign play        = (item.operation == pprb_pkg::OP_TICK) &&
                        ((mode_ff == pprb_pkg::MODE_CFG_PLAY) ||
                         (mode_ff == pprb_pkg::MODE_STIM_PLAY)) &&
                        (occ_pre != '0) && (item.periods != '0);

   always_comb begin
      mode_in = mode_ff;
      if (fire) begin
         unique case (item.operation) inside
            pprb_pkg::OP_STIM: mode_in = pprb_pkg::MODE_STIM_WAIT;
            pprb_pkg::OP_IDLE: mode_in = pprb_pkg::MODE_IDLE;
            pprb_pkg::OP_CFG:  mode_in = pprb_pkg::MODE_CFG_WAIT;
            pprb_pkg::OP_DATA: begin
               if (full_hit) begin
                  mode_in = pprb_pkg::MODE_IDLE;
               end
            end
            pprb_pkg::OP_TICK: begin
               unique case (mode_ff)
                  pprb_pkg::MODE_CFG_WAIT: begin
                     if (prefill_hit) begin
                        mode_in = pprb_pkg::MODE_CFG_PLAY;
                     end
                  end
                  pprb_pkg::MODE_STIM_WAIT: begin
                     if (prefill_hit) begin
                        mode_in = pprb_pkg::MODE_STIM_PLAY;
                     end
                  end
                  pprb_pkg::MODE_CFG_PLAY, pprb_pkg::MODE_STIM_PLAY: begin
                     if (occ_pre == '0) begin
                        mode_in = pprb_pkg::MODE_IDLE;
                     end
                  end
                  default: mode_in = mode_ff;
               endcase
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   always_comb begin
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      ram_we        = 1'b0;
      dac_valid     = 1'b0;
      dac_from_ring = 1'b0;
      dac_value     = '0;
      led_valid     = 1'b0;
      led_from_ring = 1'b0;
      event_res     = pprb_pkg::EV_NONE;
      if (fire) begin
         unique case (item.operation) inside
            pprb_pkg::OP_STIM, pprb_pkg::OP_IDLE, pprb_pkg::OP_CFG: begin
               rd_in = '0;
               wr_in = '0;
               if (item.operation == pprb_pkg::OP_IDLE) begin
                  dac_valid = 1'b1;
                  dac_value = midpoint;
                  led_valid = 1'b1;
               end
            end
            pprb_pkg::OP_DATA: begin
               ram_we = 1'b1;
               wr_in  = wr_inc;
               if (full_hit) begin
                  event_res = pprb_pkg::EV_FULL;
               end
            end
            pprb_pkg::OP_TICK: begin
               if (((mode_ff == pprb_pkg::MODE_CFG_PLAY) ||
                    (mode_ff == pprb_pkg::MODE_STIM_PLAY)) && (occ_pre == '0)) begin
                  event_res = pprb_pkg::EV_EMPTY;
               end
               if (play) begin
                  rd_in = rd_adv;
                  if (mode_ff == pprb_pkg::MODE_STIM_PLAY) begin
                     dac_valid     = 1'b1;
                     dac_from_ring = 1'b1;
                  end else begin
                     led_valid     = 1'b1;
                     led_from_ring = 1'b1;
                  end
               end
            end
            default: rd_in = rd_ff;
         endcase
      end
   end

   assign occ_post_cw = CW'(ring_fill(wr_in, rd_in));
   assign ram_waddr   = wr_ff;
   assign ram_wdata   = is_cfg ? item.data_byte : scaled;
   assign ram_re      = fire;
   assign ram_raddr   = rd_ff;

   assign result = '{
      dac_valid:     dac_valid,
      dac_from_ring: dac_from_ring,
      dac_value:     dac_value,
      led_valid:     led_valid,
      led_from_ring: led_from_ring,
      mode:          mode_in,
      event_res:     event_res,
      occupancy:     (occ_post_cw > CW'(pprb_pkg::OCC_MAX)) ? pprb_pkg::OCC_MAX
                                                             : occ_post_cw[6:0]
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pprb_pkg::MODE_IDLE;
         rd_ff   <= '0;
         wr_ff   <= '0;
      end else begin
         mode_ff <= mode_in;
         rd_ff   <= rd_in;
         wr_ff   <= wr_in;
      end
   end

   a_cmd_clears_indices: assert property (@(posedge clock) disable iff (reset)
      fire && ((item.operation == pprb_pkg::OP_STIM) || (item.operation == pprb_pkg::OP_IDLE) ||
               (item.operation == pprb_pkg::OP_CFG))
      |=> (rd_ff == '0) && (wr_ff == '0))
      else $error("mode command did not clear ring indices");

   a_full_drops_to_idle: assert property (@(posedge clock) disable iff (reset)
      fire && (item.operation == pprb_pkg::OP_DATA) && full_hit
      |=> (mode_ff == pprb_pkg::MODE_IDLE) && (rd_ff == wr_ff))
      else $error("full ring did not stop playback");

   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      fire && (item.operation == pprb_pkg::OP_TICK) && (mode_ff == pprb_pkg::MODE_IDLE)
      |=> $stable(rd_ff) && (mode_ff == pprb_pkg::MODE_IDLE))
      else $error("tick in idle changed state");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rd_ff} < (AW+1)'(RING_DEPTH)) && ({1'b0, wr_ff} < (AW+1)'(RING_DEPTH)))
      else $error("ring index out of range");

endmodule

// ===== rtl/prefill_playout_ring_buffer.sv =====
// Top level of the prefill playout ring buffer: pipeline, registers and result port.
//
// Every accepted transaction yields exactly one result. It passes an input
// register, a stage that holds the scaling product and commits mode and
// index updates with one read and, for data items, one write of the sample
// RAM, and a result register that carries the RAM read data. One transaction
// is accepted per cycle while the result port is not stalled; a stalled
// result port lets the earlier stages fill before req_ready drops. The
// sample ring is a single RAM of RING_DEPTH bytes that is not cleared: only
// entries written since the last mode command are ever played.
module prefill_playout_ring_buffer #(
   parameter int RING_DEPTH = pprb_pkg::RING_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_data_byte,
   input  logic [2:0] req_periods,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_dac_valid,
   output logic [7:0] rsp_dac_value,
   output logic       rsp_led_valid,
   output logic       rsp_led_on,
   output logic [2:0] rsp_mode,
   output logic [1:0] rsp_event_res,
   output logic [6:0] rsp_occupancy,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int AW = $clog2(RING_DEPTH);

   logic [6:0] prefill_ff;
   logic [7:0] level_high_ff;
   logic [7:0] level_low_ff;
   logic [7:0] led_threshold_ff;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   pprb_pkg::item_type   s1_item_ff;
   logic                 s2_valid_ff;
   logic                 s2_valid_in;
   pprb_pkg::item_type   s2_item_ff;
   logic                 s3_valid_ff;
   logic                 s3_valid_in;
   pprb_pkg::result_type s3_res_ff;
   pprb_pkg::result_type s3_res_in;

   logic en1;
   logic en2;
   logic en3;
   logic fire;

   logic [7:0]    scaled;
   logic [8:0]    level_sum;
   logic [7:0]    midpoint;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefill_ff       <= pprb_pkg::PREFILL_RST;
         level_high_ff    <= pprb_pkg::LEVEL_HIGH_RST;
         level_low_ff     <= pprb_pkg::LEVEL_LOW_RST;
         led_threshold_ff <= pprb_pkg::LED_THRESHOLD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pprb_pkg::CSR_PREFILL:       prefill_ff       <= csr_wdata[6:0];
            pprb_pkg::CSR_LEVEL_HIGH:    level_high_ff    <= csr_wdata;
            pprb_pkg::CSR_LEVEL_LOW:     level_low_ff     <= csr_wdata;
            pprb_pkg::CSR_LED_THRESHOLD: led_threshold_ff <= csr_wdata;
            default:                     prefill_ff       <= prefill_ff;
         endcase
      end
   end

   assign en3  = !s3_valid_ff || rsp_ready;
   assign en2  = !s2_valid_ff || en3;
   assign en1  = !s1_valid_ff || en2;
   assign fire = s2_valid_ff && en3;

   assign s1_valid_in = en1 ? req_valid : s1_valid_ff;
   assign s2_valid_in = en2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = en3 ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_item_ff <= '{operation: req_operation, data_byte: req_data_byte,
                         periods: req_periods};
      end
      if (en2) begin
         s2_item_ff <= s1_item_ff;
      end
      if (en3) begin
         s3_res_ff <= s3_res_in;
      end
   end

   assign level_sum = {1'b0, level_high_ff} + {1'b0, level_low_ff};
   assign midpoint  = level_sum[8:1];

   pprb_scale u_scale (
      .clock      (clock),
      .load       (en2),
      .data_byte  (s1_item_ff.data_byte),
      .level_low  (level_low_ff),
      .level_high (level_high_ff),
      .scaled     (scaled)
   );

   pprb_ctrl #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .item          (s2_item_ff),
      .scaled        (scaled),
      .prefill_level (prefill_ff),
      .midpoint      (midpoint),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_re        (ram_re),
      .ram_raddr     (ram_raddr),
      .result        (s3_res_in)
   );

   pprb_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready     = en1;
   assign rsp_valid     = s3_valid_ff;
   assign rsp_dac_valid = s3_res_ff.dac_valid;
   assign rsp_dac_value = s3_res_ff.dac_from_ring ? ram_rdata : s3_res_ff.dac_value;
   assign rsp_led_valid = s3_res_ff.led_valid;
   assign rsp_led_on    = s3_res_ff.led_from_ring && (ram_rdata > led_threshold_ff);
   assign rsp_mode      = s3_res_ff.mode;
   assign rsp_event_res = s3_res_ff.event_res;
   assign rsp_occupancy = s3_res_ff.occupancy;

endmodule
